@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pcrd_pkg.sv @@
// Shared types and constants of the PCA residual CUSUM detector.
`default_nettype none
package pcrd_pkg;

   localparam int MAX_FEATURES_DEF = 16;
   localparam int MAX_BASELINE_DEF = 1024;

   // Item kinds
   localparam logic [2:0] KIND_PROJ    = 3'd0;
   localparam logic [2:0] KIND_MEAN    = 3'd1;
   localparam logic [2:0] KIND_BASE    = 3'd2;
   localparam logic [2:0] KIND_FEATURE = 3'd3;
   localparam logic [2:0] KIND_CLEAR   = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_FEATURE_COUNT   = 2'd0;
   localparam logic [1:0] REG_BASELINE_COUNT  = 2'd1;
   localparam logic [1:0] REG_LOG_ALPHA       = 2'd2;
   localparam logic [1:0] REG_ALARM_THRESHOLD = 2'd3;

   // Register reset values
   localparam logic [4:0]  FEATURE_COUNT_RST   = 5'd16;
   localparam logic [10:0] BASELINE_COUNT_RST  = 11'd1;
   localparam logic [31:0] LOG_ALPHA_RST       = 32'd45426;
   localparam logic [30:0] ALARM_THRESHOLD_RST = 31'd327680;

   // ln(2) in Q0.32, rounded
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef struct packed {
      logic [2:0]         kind;
      logic [9:0]         index;
      logic signed [47:0] value;
   } req_word_type;

   typedef struct packed {
      logic        anomaly;
      logic [30:0] statistic;
      logic [46:0] residual;
      logic [10:0] exceed_count;
   } rsp_word_type;

endpackage
`default_nettype wire

@@ rtl/core/pcrd_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module pcrd_mul (
   input  wire logic               clock,
   input  wire logic signed [32:0] op_a,
   input  wire logic signed [32:0] op_b,
   output logic signed [65:0]      prod
);

   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   // Multiply the held operands
   assign prod_in = op_a * op_b;

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

@@ rtl/core/pca_residual_cusum_detector_unit.sv @@
// Top level: PCA residual CUSUM detector with one shared multiplier.
// Loads and clears are taken without leaving idle. A feature subtracts its mean,
// then takes one projection row per pass of the shared multiplier, P rows in use.
// A completing feature then squares and sums the P accumulators, scans the N2
// baseline entries and evaluates two ln values before the result word is output.
// Reset (synchronous, active high) clears control, registers and accumulators.
`default_nettype none
module pca_residual_cusum_detector_unit #(
   parameter int MAX_FEATURES = pcrd_pkg::MAX_FEATURES_DEF,
   parameter int MAX_BASELINE = pcrd_pkg::MAX_BASELINE_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pcrd_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pcrd_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [31:0]            csr_data
);

   localparam int MW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int FW  = $clog2(MAX_FEATURES + 1);
   localparam int PW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES * MAX_FEATURES) : 1;
   localparam int BAW = (MAX_BASELINE > 1) ? $clog2(MAX_BASELINE) : 1;
   localparam int CW  = $clog2(MAX_BASELINE + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_RD, S_OP, S_MWT, S_MACC,
      S_SQ_OP, S_SQ_WT, S_SQ_ACC, S_CNT,
      S_LN_NORM, S_LN_OP, S_LN_WT, S_LN_SQ, S_LN_FOP, S_LN_FMW, S_LN_FWT
   } state_type;

   // Final steps share the wait states through a phase flag
   logic fin_phase_ff, fin_phase_in;

   state_type state_ff, state_in;

   // Configuration registers
   logic [4:0]         fcnt_ff;
   logic [10:0]        bcnt_ff;
   logic signed [31:0] lalpha_ff;
   logic [30:0]        thr_ff;

   // Stores
   logic signed [31:0] proj_mem [MAX_FEATURES * MAX_FEATURES];
   logic signed [31:0] mean_mem [MAX_FEATURES];
   logic [46:0]        base_mem [MAX_BASELINE];
   logic signed [31:0] proj_q_ff;
   logic [46:0]        bq_ff;

   // Datapath registers
   logic [9:0]         idx_ff, idx_in;
   logic signed [47:0] val_ff, val_in;
   logic signed [31:0] d_ff, d_in;
   logic [FW-1:0]      row_ff, row_in;
   logic [4:0]         seen_ff, seen_in;
   logic signed [63:0] acc_ff [MAX_FEATURES];
   logic signed [63:0] acc_in [MAX_FEATURES];
   logic [46:0]        res_ff, res_in;
   logic [CW-1:0]      bi_ff, bi_in;
   logic               bvld_ff, bvld_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [31:0]        m_ff, m_in;
   logic [4:0]         e_ff, e_in;
   logic [15:0]        frac_ff, frac_in;
   logic [3:0]         k_ff, k_in;
   logic               lnsel_ff, lnsel_in;
   logic [20:0]        ln_n2_ff, ln_n2_in;
   logic [20:0]        ln_c_ff, ln_c_in;
   logic [30:0]        stat_ff, stat_in;
   logic signed [32:0] op_a_ff, op_a_in;
   logic signed [32:0] op_b_ff, op_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pcrd_pkg::rsp_word_type rsp_ff, rsp_in;

   logic signed [65:0] prod;
   logic               req_accept;
   logic [FW-1:0]      p_used;
   logic [CW-1:0]      n2_used;

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -49'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

   pcrd_mul u_mul (
      .clock (clock),
      .op_a  (op_a_ff),
      .op_b  (op_b_ff),
      .prod  (prod)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // Clamp the counts in use
   always_comb begin
      int fc;
      int bc;
      fc = int'(fcnt_ff);
      bc = int'(bcnt_ff);
      if (fc < 1) fc = 1;
      if (fc > MAX_FEATURES) fc = MAX_FEATURES;
      if (bc < 1) bc = 1;
      if (bc > MAX_BASELINE) bc = MAX_BASELINE;
      p_used  = FW'(fc);
      n2_used = CW'(bc);
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff   <= pcrd_pkg::FEATURE_COUNT_RST;
         bcnt_ff   <= pcrd_pkg::BASELINE_COUNT_RST;
         lalpha_ff <= pcrd_pkg::LOG_ALPHA_RST;
         thr_ff    <= pcrd_pkg::ALARM_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pcrd_pkg::REG_FEATURE_COUNT:   fcnt_ff   <= csr_data[4:0];
            pcrd_pkg::REG_BASELINE_COUNT:  bcnt_ff   <= csr_data[10:0];
            pcrd_pkg::REG_LOG_ALPHA:       lalpha_ff <= csr_data;
            pcrd_pkg::REG_ALARM_THRESHOLD: thr_ff    <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // Projection store: write on load, read one row entry per pass
   always_ff @(posedge clock) begin
      if (req_accept && req_word.kind == pcrd_pkg::KIND_PROJ &&
          int'(req_word.index) < MAX_FEATURES * MAX_FEATURES) begin
         proj_mem[PW'(req_word.index)] <= sat32({req_word.value[47], req_word.value});
      end
      if (state_ff == S_RD) begin
         proj_q_ff <= proj_mem[PW'(int'(row_ff) * MAX_FEATURES + int'(idx_ff))];
      end
   end

   // Mean store
   always_ff @(posedge clock) begin
      if (req_accept && req_word.kind == pcrd_pkg::KIND_MEAN &&
          int'(req_word.index) < MAX_FEATURES) begin
         mean_mem[MW'(req_word.index)] <= sat32({req_word.value[47], req_word.value});
      end
   end

   // Baseline store: write on load, scan one entry per cycle
   always_ff @(posedge clock) begin
      if (req_accept && req_word.kind == pcrd_pkg::KIND_BASE &&
          int'(req_word.index) < MAX_BASELINE) begin
         base_mem[BAW'(req_word.index)] <= req_word.value[47] ? 47'd0 : req_word.value[46:0];
      end
      if (state_ff == S_CNT && bi_ff < n2_used) begin
         bq_ff <= base_mem[BAW'(bi_ff)];
      end
   end

   // Sequencer next-state and datapath
   always_comb begin
      logic signed [48:0] diff;
      logic signed [47:0] c;
      logic signed [48:0] mag;
      logic [30:0]        m31;
      logic [47:0]        rsum;
      logic [32:0]        sq;
      logic [52:0]        lnsum;
      logic [20:0]        lnr;
      logic signed [34:0] g;
      logic [30:0]        gc;
      logic [5:0]         seen_nx;

      state_in     = state_ff;
      fin_phase_in = fin_phase_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      d_in         = d_ff;
      row_in       = row_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      bi_in        = bi_ff;
      bvld_in      = bvld_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      frac_in      = frac_ff;
      k_in         = k_ff;
      lnsel_in     = lnsel_ff;
      ln_n2_in     = ln_n2_ff;
      ln_c_in      = ln_c_ff;
      stat_in      = stat_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      diff    = {val_ff[47], val_ff} - 49'(mean_mem[MW'(idx_ff)]);
      c       = acc_ff[row_ff[MW-1:0]][63:16];
      mag     = c[47] ? -{c[47], c} : {c[47], c};
      m31     = (mag > 49'sd2147483647) ? 31'h7FFFFFFF : mag[30:0];
      rsum    = {1'b0, res_ff} + {2'b00, prod[61:16]};
      sq      = prod[63:31];
      lnsum   = prod[52:0] + 53'(64'h80000000);
      lnr     = lnsum[52:32];
      g       = $signed({4'b0000, stat_ff}) + $signed({{3{lalpha_ff[31]}}, lalpha_ff})
                + $signed({14'd0, ln_n2_ff}) - $signed({14'd0, ln_c_ff});
      gc      = g[34] ? 31'd0 : ((g > 35'sd2147483647) ? 31'h7FFFFFFF : g[30:0]);
      seen_nx = {1'b0, seen_ff} + 6'd1;

      case (state_ff)
         S_IDLE: begin
            // Take an item
            if (req_accept) begin
               case (req_word.kind)
                  pcrd_pkg::KIND_CLEAR: stat_in = 31'd0;
                  pcrd_pkg::KIND_FEATURE: begin
                     if (int'(req_word.index) < int'(p_used)) begin
                        idx_in   = req_word.index;
                        val_in   = req_word.value;
                        state_in = S_DIFF;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIFF: begin
            // Subtract the mean
            d_in     = sat32(diff);
            row_in   = '0;
            state_in = S_RD;
         end
         S_RD: state_in = S_OP;
         S_OP: begin
            op_a_in  = {proj_q_ff[31], proj_q_ff};
            op_b_in  = {d_ff[31], d_ff};
            state_in = S_MWT;
         end
         S_MWT: state_in = S_MACC;
         S_MACC: begin
            // Accumulate one row, then advance or finish the feature
            acc_in[row_ff[MW-1:0]] = sat_add64(acc_ff[row_ff[MW-1:0]], prod[63:0]);
            if (row_ff == p_used - FW'(1)) begin
               seen_in = seen_nx[4:0];
               if (int'(seen_nx) >= int'(p_used)) begin
                  row_in   = '0;
                  res_in   = 47'd0;
                  state_in = S_SQ_OP;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               row_in   = row_ff + FW'(1);
               state_in = S_RD;
            end
         end
         S_SQ_OP: begin
            op_a_in  = {2'b00, m31};
            op_b_in  = {2'b00, m31};
            state_in = S_SQ_WT;
         end
         S_SQ_WT: state_in = S_SQ_ACC;
         S_SQ_ACC: begin
            // Sum the squares with saturation
            res_in = rsum[47] ? {47{1'b1}} : rsum[46:0];
            if (row_ff == p_used - FW'(1)) begin
               for (int i = 0; i < MAX_FEATURES; i++) begin
                  acc_in[i] = 64'sd0;
               end
               seen_in  = 5'd0;
               bi_in    = '0;
               bvld_in  = 1'b0;
               cnt_in   = '0;
               state_in = S_CNT;
            end else begin
               row_in   = row_ff + FW'(1);
               state_in = S_SQ_OP;
            end
         end
         S_CNT: begin
            // Scan the baseline, one compare per cycle
            bvld_in = (bi_ff < n2_used);
            if (bi_ff < n2_used) begin
               bi_in = bi_ff + CW'(1);
            end
            if (bvld_ff && bq_ff >= res_ff) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (!(bi_ff < n2_used) && !bvld_ff) begin
               m_in         = 32'(n2_used);
               e_in         = 5'd31;
               lnsel_in     = 1'b0;
               fin_phase_in = 1'b0;
               state_in     = S_LN_NORM;
            end
         end
         S_LN_NORM: begin
            // Normalize to Q1.31, one bit per cycle
            if (m_ff[31]) begin
               frac_in  = 16'd0;
               k_in     = 4'd0;
               state_in = S_LN_OP;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               e_in = e_ff - 5'd1;
            end
         end
         S_LN_OP: begin
            op_a_in  = {1'b0, m_ff};
            op_b_in  = {1'b0, m_ff};
            state_in = S_LN_WT;
         end
         S_LN_WT: state_in = S_LN_SQ;
         S_LN_SQ: begin
            // One fraction bit of log2 per squaring
            if (sq[32]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               m_in    = sq[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               m_in    = sq[31:0];
            end
            if (k_ff == 4'd15) begin
               state_in = S_LN_FOP;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = S_LN_OP;
            end
         end
         S_LN_FOP: begin
            if (fin_phase_ff) begin
               // Emit the result word once the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.anomaly         = (gc >= thr_ff);
                  rsp_in.statistic       = gc;
                  rsp_in.residual        = res_ff;
                  rsp_in.exceed_count    = 11'(cnt_ff);
                  stat_in                = gc;
                  fin_phase_in           = 1'b0;
                  state_in               = S_IDLE;
               end
            end else begin
               op_a_in  = {12'd0, e_ff, frac_ff};
               op_b_in  = {1'b0, pcrd_pkg::LN2_Q32};
               state_in = S_LN_FMW;
            end
         end
         // Wait for the scaled product
         S_LN_FMW: state_in = S_LN_FWT;
         S_LN_FWT: begin
            // Scale log2 by ln 2, rounding half up
            if (!lnsel_ff) begin
               ln_n2_in = lnr;
               lnsel_in = 1'b1;
               m_in     = (cnt_ff == '0) ? 32'd1 : 32'(cnt_ff);
               e_in     = 5'd31;
               state_in = S_LN_NORM;
            end else begin
               ln_c_in      = lnr;
               fin_phase_in = 1'b1;
               state_in     = S_LN_FOP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, datapath and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fin_phase_ff <= 1'b0;
         seen_ff      <= 5'd0;
         stat_ff      <= 31'd0;
         rsp_valid_ff <= 1'b0;
         bvld_ff      <= 1'b0;
         lnsel_ff     <= 1'b0;
         for (int i = 0; i < MAX_FEATURES; i++) begin
            acc_ff[i] <= 64'sd0;
         end
      end else begin
         state_ff     <= state_in;
         fin_phase_ff <= fin_phase_in;
         seen_ff      <= seen_in;
         stat_ff      <= stat_in;
         rsp_valid_ff <= rsp_valid_in;
         bvld_ff      <= bvld_in;
         lnsel_ff     <= lnsel_in;
         acc_ff       <= acc_in;
      end
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      d_ff     <= d_in;
      row_ff   <= row_in;
      res_ff   <= res_in;
      bi_ff    <= bi_in;
      cnt_ff   <= cnt_in;
      m_ff     <= m_in;
      e_ff     <= e_in;
      frac_ff  <= frac_in;
      k_ff     <= k_in;
      ln_n2_ff <= ln_n2_in;
      ln_c_ff  <= ln_c_in;
      op_a_ff  <= op_a_in;
      op_b_ff  <= op_b_in;
      rsp_ff   <= rsp_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/pcrd_checker.sv @@
// Port checker for the detector and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module pcrd_checker #(
   parameter int MAX_BASELINE = pcrd_pkg::MAX_BASELINE_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire pcrd_pkg::req_word_type req_word,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire pcrd_pkg::rsp_word_type rsp_word
);

   // Stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "result word dropped or changed while stalled")

   // Count never exceeds the baseline depth
   `ASSERT_SAME(a_count_range, clock, reset, rsp_valid, 32'(rsp_word.exceed_count) <= MAX_BASELINE, "exceed count beyond baseline depth")

   // Loads and clears leave the block ready again in the next cycle
   `ASSERT_NEXT(a_load_fast, clock, reset, req_valid && !req_stall && req_word.kind != pcrd_pkg::KIND_FEATURE, !req_stall, "block busy after a load")

   // Reset leaves the block ready and empty
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !req_stall && !rsp_valid, "block not idle after reset")

endmodule

bind pca_residual_cusum_detector_unit pcrd_checker #(
   .MAX_BASELINE (MAX_BASELINE)
) u_pcrd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
`default_nettype wire
